// File: rtl/core/qsc_pkg.sv
// Shared beat types and constants for the smallest-three quaternion codec.
`default_nettype none
package qsc_pkg;

	localparam logic ACT_ENCODE = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	localparam int NUM_KEPT   = 3;
	localparam int ROOT_STEPS = 15;

	localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;
	localparam logic [46:0] ENC_OFFSET    = 47'd70366596694016;
	localparam logic [46:0] FULL_SCALE    = 47'd140733193388032;
	localparam logic [29:0] UNIT_SQ       = 30'd1073676289;
	localparam logic [15:0] LEVELS_WIDE   = 16'd65535;
	localparam logic [15:0] LEVELS_NARROW = 16'd16383;

	typedef struct packed {
		logic               action;
		logic signed [15:0] comp_x;
		logic signed [15:0] comp_y;
		logic signed [15:0] comp_z;
		logic signed [15:0] comp_w;
		logic [15:0]        word_a;
		logic [15:0]        word_b;
		logic [15:0]        word_c;
	} cmd_beat_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [15:0] out_z;
		logic signed [15:0] out_w;
		logic [15:0]        code_a;
		logic [15:0]        code_b;
		logic [15:0]        code_c;
	} res_beat_t;

	typedef struct packed {
		logic            act;
		logic [1:0]      idx;
		logic [15:0]     code_a;
		logic [15:0]     code_b;
		logic [15:0]     code_c;
		logic [2:0][15:0] kept;
	} carry_t;

endpackage
`default_nettype wire

// File: rtl/core/quaternion_smallest_three_codec.sv
// Pipelined smallest-three quaternion encoder and decoder in 48 bits.
// Throughput: one beat per cycle while res_ready does not stall the pipeline; the square root
// resolves one result bit per stage over fifteen stages.
// Reset clears only the stage valid bits; the datapath registers are not reset.
`default_nettype none
module quaternion_smallest_three_codec (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  qsc_pkg::cmd_beat_t    cmd,
	output logic                  res_valid,
	input  logic                  res_ready,
	output qsc_pkg::res_beat_t    res
);
	import qsc_pkg::*;

	localparam int SQ_FIRST = 11;
	localparam int SQ_LAST  = SQ_FIRST + ROOT_STEPS - 1;
	localparam int NS       = SQ_LAST + 1;
	localparam logic [15:0] LEV [NUM_KEPT] = '{LEVELS_WIDE, LEVELS_WIDE, LEVELS_NARROW};

	logic [NS:1] vld_s;
	logic [NS:1] adv;

	always_comb begin
		adv[NS] = ~vld_s[NS] | res_ready;
		for (int k = NS - 1; k >= 1; k--) begin
			adv[k] = ~vld_s[k] | adv[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = NS; k >= 2; k--) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k - 1];
				end
			end
			if (adv[1]) begin
				vld_s[1] <= cmd_valid;
			end
		end
	end

	assign cmd_ready = adv[1];
	assign res_valid = vld_s[NS];

	// Stage 1: command register.
	cmd_beat_t cmd_s1;
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			cmd_s1 <= cmd;
		end
	end

	// Stage 2: largest component and decode code magnitudes.
	logic signed [15:0] comp_in [4];
	logic [16:0]        mag_in [4];
	logic [1:0]         big_idx;
	logic               big_neg;
	logic [15:0]        wd [NUM_KEPT];
	logic [15:0]        dmag [NUM_KEPT];
	logic               dneg [NUM_KEPT];

	assign comp_in[0] = cmd_s1.comp_x;
	assign comp_in[1] = cmd_s1.comp_y;
	assign comp_in[2] = cmd_s1.comp_z;
	assign comp_in[3] = cmd_s1.comp_w;
	assign wd[0] = cmd_s1.word_a;
	assign wd[1] = cmd_s1.word_b;
	assign wd[2] = {2'b00, cmd_s1.word_c[13:0]};

	always_comb begin
		logic [16:0] best;
		for (int i = 0; i < 4; i++) begin
			mag_in[i] = comp_in[i][15] ? (17'd0 - {1'b1, comp_in[i]}) : {1'b0, comp_in[i]};
		end
		best = mag_in[0];
		big_idx = 2'd0;
		for (int i = 1; i < 4; i++) begin
			if (mag_in[i] > best) begin
				best = mag_in[i];
				big_idx = 2'(i);
			end
		end
		big_neg = comp_in[big_idx][15];
	end

	always_comb begin
		logic [16:0] twice;
		for (int k = 0; k < NUM_KEPT; k++) begin
			twice = {wd[k], 1'b0};
			dneg[k] = twice < {1'b0, LEV[k]};
			dmag[k] = dneg[k] ? 16'({1'b0, LEV[k]} - twice) : 16'(twice - {1'b0, LEV[k]});
		end
	end

	logic               act_s2;
	logic [1:0]         idx_s2;
	logic               neg_s2;
	logic signed [15:0] comp_s2 [4];
	logic [15:0]        dmag_s2 [NUM_KEPT];
	logic               dneg_s2 [NUM_KEPT];

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			act_s2  <= cmd_s1.action;
			idx_s2  <= (cmd_s1.action == ACT_DECODE) ? cmd_s1.word_c[15:14] : big_idx;
			neg_s2  <= big_neg;
			comp_s2 <= comp_in;
			dmag_s2 <= dmag;
			dneg_s2 <= dneg;
		end
	end

	// Stage 3: sign-adjusted kept components, scaled code magnitudes.
	logic signed [16:0] ev [NUM_KEPT];
	logic [30:0]        dp [NUM_KEPT];

	always_comb begin
		logic [1:0]  src;
		logic [16:0] ext;
		for (int k = 0; k < NUM_KEPT; k++) begin
			src = (2'(k) >= idx_s2) ? 2'(k + 1) : 2'(k);
			ext = {comp_s2[src][15], comp_s2[src]};
			ev[k] = neg_s2 ? (17'd0 - ext) : ext;
			dp[k] = {dmag_s2[k], 15'b0} - {15'b0, dmag_s2[k]};
		end
	end

	logic               act_s3;
	logic [1:0]         idx_s3;
	logic signed [16:0] ev_s3 [NUM_KEPT];
	logic [30:0]        dp_s3 [NUM_KEPT];
	logic               dneg_s3 [NUM_KEPT];

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			act_s3  <= act_s2;
			idx_s3  <= idx_s2;
			ev_s3   <= ev;
			dp_s3   <= dp;
			dneg_s3 <= dneg_s2;
		end
	end

	// Stage 4: multiplications by 1/sqrt2 in Q32.
	logic               act_s4;
	logic [1:0]         idx_s4;
	logic signed [49:0] ep_s4 [NUM_KEPT];
	logic [62:0]        dx_s4 [NUM_KEPT];
	logic               dneg_s4 [NUM_KEPT];

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			act_s4  <= act_s3;
			idx_s4  <= idx_s3;
			dneg_s4 <= dneg_s3;
			for (int k = 0; k < NUM_KEPT; k++) begin
				ep_s4[k] <= 50'(ev_s3[k]) * 50'($signed({1'b0, INV_SQRT2_Q32}));
				dx_s4[k] <= 63'(dp_s3[k]) * 63'(INV_SQRT2_Q32);
			end
		end
	end

	// Stage 5: offset and clamp for encode, rounding offset for decode.
	logic [46:0] en [NUM_KEPT];
	logic [31:0] dy [NUM_KEPT];

	always_comb begin
		logic signed [49:0] ns;
		logic [63:0]        ys;
		for (int k = 0; k < NUM_KEPT; k++) begin
			ns = ep_s4[k] + $signed({3'b000, ENC_OFFSET});
			if (ns[49]) begin
				en[k] = '0;
			end else if (ns[48:0] > {2'b00, FULL_SCALE}) begin
				en[k] = FULL_SCALE;
			end else begin
				en[k] = ns[46:0];
			end
			ys = {1'b0, dx_s4[k]} + ({48'b0, LEV[k]} << 31);
			dy[k] = ys[63:32];
		end
	end

	logic        act_s5;
	logic [1:0]  idx_s5;
	logic [46:0] en_s5 [NUM_KEPT];
	logic [31:0] dy_s5 [NUM_KEPT];
	logic        dneg_s5 [NUM_KEPT];

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			act_s5  <= act_s4;
			idx_s5  <= idx_s4;
			en_s5   <= en;
			dy_s5   <= dy;
			dneg_s5 <= dneg_s4;
		end
	end

	// Stage 6: split quotient and remainder terms for both divisions by a constant.
	logic [15:0] eq [NUM_KEPT];
	logic [47:0] et [NUM_KEPT];
	logic [17:0] dq0 [NUM_KEPT];
	logic [18:0] drem [NUM_KEPT];

	always_comb begin
		for (int k = 0; k < NUM_KEPT; k++) begin
			if (k < 2) begin
				eq[k]   = en_s5[k][46:31];
				et[k]   = {1'b0, ({en_s5[k][30:0], 16'b0} - {15'b0, en_s5[k][30:0], 1'b0})};
				dq0[k]  = {2'b00, dy_s5[k][31:16]};
				drem[k] = {3'b000, dy_s5[k][15:0]} + {1'b0, dq0[k]};
			end else begin
				eq[k]   = {2'b00, en_s5[k][46:33]};
				et[k]   = {en_s5[k][32:0], 15'b0} - {15'b0, en_s5[k][32:0]};
				dq0[k]  = dy_s5[k][31:14];
				drem[k] = {5'b0, dy_s5[k][13:0]} + {1'b0, dq0[k]};
			end
		end
	end

	logic        act_s6;
	logic [1:0]  idx_s6;
	logic [15:0] eq_s6 [NUM_KEPT];
	logic [47:0] et_s6 [NUM_KEPT];
	logic [46:0] en_s6 [NUM_KEPT];
	logic [17:0] dq0_s6 [NUM_KEPT];
	logic [18:0] drem_s6 [NUM_KEPT];
	logic        dneg_s6 [NUM_KEPT];

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			act_s6  <= act_s5;
			idx_s6  <= idx_s5;
			eq_s6   <= eq;
			et_s6   <= et;
			en_s6   <= en_s5;
			dq0_s6  <= dq0;
			drem_s6 <= drem;
			dneg_s6 <= dneg_s5;
		end
	end

	// Stage 7: quotient corrections.
	logic [15:0] code [NUM_KEPT];
	logic [14:0] dq [NUM_KEPT];

	always_comb begin
		logic [48:0] sum;
		logic [17:0] q;
		for (int k = 0; k < NUM_KEPT; k++) begin
			sum = {1'b0, et_s6[k]} + {2'b00, en_s6[k]};
			if (k < 2) begin
				code[k] = eq_s6[k] + 16'(sum >= {2'b00, FULL_SCALE});
				q = dq0_s6[k] + 18'(drem_s6[k] >= {3'b000, LEV[k]});
			end else begin
				code[k] = eq_s6[k] - 16'(et_s6[k] < {1'b0, en_s6[k]});
				if (drem_s6[k] >= {2'b00, LEV[k], 1'b0}) begin
					q = dq0_s6[k] + 18'd2;
				end else if (drem_s6[k] >= {3'b000, LEV[k]}) begin
					q = dq0_s6[k] + 18'd1;
				end else begin
					q = dq0_s6[k];
				end
			end
			dq[k] = q[14:0];
		end
	end

	logic        act_s7;
	logic [1:0]  idx_s7;
	logic [15:0] code_s7 [NUM_KEPT];
	logic [14:0] dq_s7 [NUM_KEPT];
	logic        dneg_s7 [NUM_KEPT];

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			act_s7  <= act_s6;
			idx_s7  <= idx_s6;
			code_s7 <= code;
			dq_s7   <= dq;
			dneg_s7 <= dneg_s6;
		end
	end

	// Stages 8 to 10: squares, their sum and the radicand.
	carry_t      cy_s [8:SQ_LAST];
	logic [29:0] sq_s8 [NUM_KEPT];
	logic [31:0] ss_s9;
	logic [29:0] rad_s10;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			cy_s[8].act    <= act_s7;
			cy_s[8].idx    <= idx_s7;
			cy_s[8].code_a <= code_s7[0];
			cy_s[8].code_b <= code_s7[1];
			cy_s[8].code_c <= {idx_s7, code_s7[2][13:0]};
			for (int k = 0; k < NUM_KEPT; k++) begin
				cy_s[8].kept[k] <= dneg_s7[k] ? (16'd0 - {1'b0, dq_s7[k]}) : {1'b0, dq_s7[k]};
				sq_s8[k] <= 30'(dq_s7[k]) * 30'(dq_s7[k]);
			end
		end
		if (adv[9]) begin
			ss_s9 <= 32'(sq_s8[0]) + 32'(sq_s8[1]) + 32'(sq_s8[2]);
		end
		if (adv[10]) begin
			rad_s10 <= (ss_s9 > 32'(UNIT_SQ)) ? 30'd0 : 30'(32'(UNIT_SQ) - ss_s9);
		end
	end

	for (genvar s = 9; s <= SQ_LAST; s++) begin : g_carry
		always_ff @(posedge clk) begin
			if (adv[s]) begin
				cy_s[s] <= cy_s[s - 1];
			end
		end
	end

	// Stages 11 to 25: square root, one result bit per stage.
	logic [29:0] sqx_s [SQ_FIRST:SQ_LAST];
	logic [30:0] sqr_s [SQ_FIRST:SQ_LAST];

	for (genvar s = SQ_FIRST; s <= SQ_LAST; s++) begin : g_root
		localparam logic [30:0] ROOT_BIT = 31'(1) << (2 * (SQ_LAST - s));
		logic [29:0] x_in;
		logic [30:0] r_in;
		logic [30:0] trial;

		if (s == SQ_FIRST) begin : g_head
			assign x_in = rad_s10;
			assign r_in = '0;
		end else begin : g_body
			assign x_in = sqx_s[s - 1];
			assign r_in = sqr_s[s - 1];
		end

		assign trial = r_in + ROOT_BIT;

		always_ff @(posedge clk) begin
			if (adv[s]) begin
				if ({1'b0, x_in} >= trial) begin
					sqx_s[s] <= 30'({1'b0, x_in} - trial);
					sqr_s[s] <= (r_in >> 1) + ROOT_BIT;
				end else begin
					sqx_s[s] <= x_in;
					sqr_s[s] <= r_in >> 1;
				end
			end
		end
	end

	// Stage 26: rounding and result assembly.
	res_beat_t res_next;
	res_beat_t res_s26;

	always_comb begin
		logic [15:0]      root;
		logic [3:0][15:0] comps;
		root = 16'(sqr_s[SQ_LAST] + 31'({1'b0, sqx_s[SQ_LAST]} > sqr_s[SQ_LAST]));
		for (int i = 0; i < 4; i++) begin
			if (2'(i) == cy_s[SQ_LAST].idx) begin
				comps[i] = root;
			end else if (2'(i) > cy_s[SQ_LAST].idx) begin
				comps[i] = cy_s[SQ_LAST].kept[i - 1];
			end else begin
				comps[i] = cy_s[SQ_LAST].kept[i];
			end
		end
		res_next = '0;
		if (cy_s[SQ_LAST].act == ACT_DECODE) begin
			res_next.out_x = comps[0];
			res_next.out_y = comps[1];
			res_next.out_z = comps[2];
			res_next.out_w = comps[3];
		end else begin
			res_next.code_a = cy_s[SQ_LAST].code_a;
			res_next.code_b = cy_s[SQ_LAST].code_b;
			res_next.code_c = cy_s[SQ_LAST].code_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NS]) begin
			res_s26 <= res_next;
		end
	end

	assign res = res_s26;

endmodule
`default_nettype wire
